[rtl/core/siphash_2_4_stream_core_assert.svh]
// Assertion macros used by the SipHash stream core checker.
// Needs nothing else; included by the checker file.
`ifndef SIPHASH_2_4_STREAM_CORE_ASSERT_SVH
`define SIPHASH_2_4_STREAM_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define SPH_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sph assertion failed");

// Next-cycle implication, disabled while reset is low.
`define SPH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sph assertion failed");

`endif

[rtl/core/sph_pkg.sv]
// Package for the SipHash-2-4 stream core: state types, init constants, round function.
// No dependencies; imported by sph_absorb, sph_finalize and the top level.
`timescale 1ns / 1ps

package sph_pkg;

    localparam logic [63:0] INIT_A  = 64'h736f6d6570736575;
    localparam logic [63:0] INIT_B  = 64'h646f72616e646f6d;
    localparam logic [63:0] INIT_C  = 64'h6c7967656e657261;
    localparam logic [63:0] INIT_D  = 64'h7465646279746573;
    localparam logic [63:0] FIN_XOR = 64'h00000000000000ff;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 2'd1;

    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] d;
    } t_sip_state;

    // Handoff from the absorb loop to the finalization pipeline.
    typedef struct packed {
        logic       valid;
        t_sip_state st;
        logic [63:0] blk;
    } t_fin_req;

    function automatic t_sip_state sip_init(input logic [63:0] k0, input logic [63:0] k1);
        t_sip_state s;
        s.a = INIT_A ^ k0;
        s.b = INIT_B ^ k1;
        s.c = INIT_C ^ k0;
        s.d = INIT_D ^ k1;
        return s;
    endfunction

    function automatic t_sip_state sip_round(input t_sip_state s);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] d;
        t_sip_state r;
        a = s.a;
        b = s.b;
        c = s.c;
        d = s.d;
        a = a + b;
        b = {b[50:0], b[63:51]};
        b = b ^ a;
        a = {a[31:0], a[63:32]};
        c = c + d;
        d = {d[47:0], d[63:48]};
        d = d ^ c;
        a = a + d;
        d = {d[42:0], d[63:43]};
        d = d ^ a;
        c = c + b;
        b = {b[46:0], b[63:47]};
        b = b ^ c;
        c = {c[31:0], c[63:32]};
        r.a = a;
        r.b = b;
        r.c = c;
        r.d = d;
        return r;
    endfunction

    function automatic t_sip_state sip_round2(input t_sip_state s);
        return sip_round(sip_round(s));
    endfunction

endpackage

[rtl/core/sph_absorb.sv]
// Absorb loop: key registers, running SipHash state, remainder buffer and length.
// Depends on sph_pkg.
`timescale 1ns / 1ps

module sph_absorb
    import sph_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [63:0]          i_data_bytes,
    input  logic [3:0]           i_byte_count,
    input  logic                 i_last,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data,
    output t_fin_req             o_req
);

    logic [63:0] r_key_low;
    logic [63:0] r_key_high;
    t_sip_state  r_st;
    logic [55:0] r_pend;
    logic [2:0]  r_pend_cnt;
    logic [7:0]  r_len;

    logic [63:0]  n_key_low;
    logic [63:0]  n_key_high;
    logic         key_we;
    t_sip_state   n_st;
    t_sip_state   st_cmp;
    logic [55:0]  n_pend;
    logic [2:0]   n_pend_cnt;
    logic [7:0]   n_len;
    logic [3:0]   cnt_clamp;
    logic [3:0]   total;
    logic [63:0]  data_m;
    logic [119:0] merged;
    logic [63:0]  blk;

    always_comb begin
        n_key_low  = r_key_low;
        n_key_high = r_key_high;
        key_we     = 1'b0;
        case (i_cfg_index)
            REG_KEY_LOW: begin
                n_key_low = i_cfg_data;
                key_we    = i_cfg_we;
            end
            REG_KEY_HIGH: begin
                n_key_high = i_cfg_data;
                key_we     = i_cfg_we;
            end
            default: ;
        endcase
    end

    always_comb begin
        cnt_clamp = (i_byte_count > 4'd8) ? 4'd8 : i_byte_count;
        for (int k = 0; k < 8; k++) begin
            data_m[k*8 +: 8] = (4'(k) < cnt_clamp) ? i_data_bytes[k*8 +: 8] : 8'd0;
        end
        total  = {1'b0, r_pend_cnt} + cnt_clamp;
        // Line new bytes up behind the remainder; bits above 63 carry into the next block.
        merged = ({56'd0, data_m} << {r_pend_cnt, 3'b000}) | {64'd0, r_pend};
        blk    = merged[63:0];

        st_cmp   = r_st;
        st_cmp.d = st_cmp.d ^ blk;
        st_cmp   = sip_round2(st_cmp);
        st_cmp.a = st_cmp.a ^ blk;

        n_st       = total[3] ? st_cmp : r_st;
        n_pend     = total[3] ? merged[119:64] : merged[55:0];
        n_pend_cnt = total[2:0];
        n_len      = r_len + {4'd0, cnt_clamp};
    end

    assign o_req.valid = i_accept & i_last;
    assign o_req.st    = n_st;
    assign o_req.blk   = {n_len, n_pend};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= 64'd0;
            r_key_high <= 64'd0;
            r_st       <= sip_init(64'd0, 64'd0);
            r_pend     <= 56'd0;
            r_pend_cnt <= 3'd0;
            r_len      <= 8'd0;
        end else if (key_we) begin
            r_key_low  <= n_key_low;
            r_key_high <= n_key_high;
            r_st       <= sip_init(n_key_low, n_key_high);
            r_pend     <= 56'd0;
            r_pend_cnt <= 3'd0;
            r_len      <= 8'd0;
        end else if (i_accept) begin
            if (i_last) begin
                r_st       <= sip_init(r_key_low, r_key_high);
                r_pend     <= 56'd0;
                r_pend_cnt <= 3'd0;
                r_len      <= 8'd0;
            end else begin
                r_st       <= n_st;
                r_pend     <= n_pend;
                r_pend_cnt <= n_pend_cnt;
                r_len      <= n_len;
            end
        end
    end

endmodule

[rtl/core/sph_finalize.sv]
// Finalization pipeline: last-block compress, 0xff mix, four rounds, fold, result register.
// Depends on sph_pkg.
`timescale 1ns / 1ps

module sph_finalize
    import sph_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_fin_req    i_req,
    input  logic        i_out_ready,
    output logic        o_advance,
    output logic        o_out_valid,
    output logic [63:0] o_hash_value
);

    logic        r_v1;
    logic        r_v2;
    logic        r_v3;
    logic        r_out_v;
    t_sip_state  r_s1;
    logic [63:0] r_blk1;
    t_sip_state  r_s2;
    t_sip_state  r_s3;
    logic [63:0] r_hash;

    t_sip_state  n_s2;
    t_sip_state  n_s3;
    t_sip_state  s_out;
    logic        advance;

    // Whole pipe moves together; it stalls only when the result is held.
    assign advance = !r_out_v || i_out_ready;

    always_comb begin
        n_s2   = r_s1;
        n_s2.d = n_s2.d ^ r_blk1;
        n_s2   = sip_round2(n_s2);
        n_s2.a = n_s2.a ^ r_blk1;
        n_s2.c = n_s2.c ^ FIN_XOR;
        n_s3   = sip_round2(r_s2);
        s_out  = sip_round2(r_s3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_out_v <= 1'b0;
        end else if (advance) begin
            r_v1    <= i_req.valid;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_out_v <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1   <= i_req.st;
            r_blk1 <= i_req.blk;
            r_s2   <= n_s2;
            r_s3   <= n_s3;
            r_hash <= s_out.a ^ s_out.b ^ s_out.c ^ s_out.d;
        end
    end

    assign o_advance    = advance;
    assign o_out_valid  = r_out_v;
    assign o_hash_value = r_hash;

endmodule

[rtl/core/siphash_2_4_stream_core.sv]
// SipHash-2-4 stream core, top level. Uses sph_pkg, sph_absorb, sph_finalize.
// Throughput: one transaction per cycle unless stalled; absorb runs two SipRounds per cycle.
// The hash of a last transaction moves through r_s1, r_s2, r_s3 and the result register;
// each step waits while the pipe is stalled.
// Backpressure on the result freezes the finalization pipe and holds input ready low.
// Reset (synchronous, active low): keys zero, state at the init constants, pipe empty.
`timescale 1ns / 1ps

module siphash_2_4_stream_core
    import sph_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input transactions
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [63:0]          i_data_bytes,
    input  logic [3:0]           i_byte_count,
    input  logic                 i_last,
    // result transactions
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [63:0]          o_hash_value,
    // key register writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data
);

    logic     advance;
    logic     in_accept;
    t_fin_req fin_req;

    // Key writes are always taken; writes to the key-low or key-high index restart the running message.
    assign o_cfg_ready = 1'b1;

    // Take a new transaction whenever the finalization pipe can move, so an
    // earlier hash may still wait in the result register.
    assign o_in_ready = advance;
    assign in_accept  = i_in_valid & advance;

    // Absorb: merge bytes into the remainder, compress a completed block,
    // and hand the state plus final block to the pipe on the last transaction.
    sph_absorb u_absorb (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (in_accept),
        .i_data_bytes (i_data_bytes),
        .i_byte_count (i_byte_count),
        .i_last       (i_last),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_req        (fin_req)
    );

    // Finalize: three two-round stages and a registered fold.
    sph_finalize u_finalize (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (fin_req),
        .i_out_ready  (i_out_ready),
        .o_advance    (advance),
        .o_out_valid  (o_out_valid),
        .o_hash_value (o_hash_value)
    );

endmodule

[rtl/core/sph_checker.sv]
// Port-level checker for the SipHash stream core, bound to the top level.
// Depends on siphash_2_4_stream_core_assert.svh.
`timescale 1ns / 1ps
`include "siphash_2_4_stream_core_assert.svh"

module sph_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic                 i_last,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic [63:0]          o_hash_value,
    input logic                 i_cfg_valid,
    input logic                 o_cfg_ready
);

    // Hold a stalled result.
    `SPH_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_hash_value))

    // Input ready follows the result side: free or draining.
    `SPH_ASSERT_NOW(a_ready_link, i_clk, i_rst_n, 1'b1, o_in_ready == (!o_out_valid || i_out_ready))

    // Key writes are never held off.
    `SPH_ASSERT_NOW(a_cfg_ready, i_clk, i_rst_n, i_cfg_valid, o_cfg_ready)

    // An unstalled last transaction shows its hash once it has passed r_v1, r_v2 and r_v3 into the result register.
    `SPH_ASSERT_NEXT(a_latency, i_clk, i_rst_n, (i_in_valid && o_in_ready && i_last && i_out_ready) ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready, o_out_valid)

endmodule

bind siphash_2_4_stream_core sph_checker u_sph_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .i_last       (i_last),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_hash_value (o_hash_value),
    .i_cfg_valid  (i_cfg_valid),
    .o_cfg_ready  (o_cfg_ready)
);
